### src/rthsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthsl_pkg
// Shared types and constants for the rgb to hsl converter pipeline.
// ----------------------------------------------------------------------------
package rthsl_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned HUE_W    = 9;
  localparam int unsigned SAT_W    = 16;
  localparam int unsigned SUM_W    = 9;
  localparam int unsigned SAT_BITS = 16;
  localparam int unsigned HUE_BITS = 7;

  localparam logic [SUM_W-1:0] SUM_HALF = 9'd255;
  localparam logic [SUM_W-1:0] SUM_FULL = 9'd510;
  localparam logic [SAT_W:0]   Q15_ONE  = 17'd32768;

  // hue base: sector offset plus 300 (the 360 bias less the 60 folded into the numerator)
  localparam logic [9:0] BASE_RED   = 10'd300;
  localparam logic [9:0] BASE_GREEN = 10'd420;
  localparam logic [9:0] BASE_BLUE  = 10'd540;
  localparam logic [9:0] FULL_TURN  = 10'd360;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic             valid;
    logic             achrom;
    logic [SUM_W-1:0] sum;
    sector_t          sector;
    logic [7:0]       sat_den;
    logic [8:0]       sat_rem;
    logic [SAT_W-1:0] sat_q;
    logic [7:0]       hue_den;
    logic [7:0]       hue_rem;
    logic [6:0]       hue_lo;
    logic [6:0]       hue_q;
  } lane_t;

endpackage

### src/rthsl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthsl_pix_if / rthsl_hsl_if
// Valid/ready channels for rgb pixel words and hsl result words.
// ----------------------------------------------------------------------------
interface rthsl_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rthsl_hsl_if;
  logic        valid;
  logic        ready;
  logic [8:0]  hue_degrees;
  logic [15:0] saturation_q15;
  logic [8:0]  lightness_sum;
  modport source (output valid, hue_degrees, saturation_q15, lightness_sum, input ready);
  modport sink   (input valid, hue_degrees, saturation_q15, lightness_sum, output ready);
endinterface

### src/rthsl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthsl_front
// Finds max, min, sector and both division operands for one pixel.
// ----------------------------------------------------------------------------
module rthsl_front (
  input  logic [7:0]     red,
  input  logic [7:0]     green,
  input  logic [7:0]     blue,
  input  logic           valid,
  output rthsl_pkg::lane_t lane
);
  import rthsl_pkg::*;

  logic [7:0]  mx, mn, rg_max, rg_min, delta, up, down;
  logic [8:0]  sum, far, dsum;
  logic [14:0] num;
  sector_t     sector;

  always_comb begin
    rg_max = (red >= green) ? red : green;
    mx     = (rg_max >= blue) ? rg_max : blue;
    rg_min = (red <= green) ? red : green;
    mn     = (rg_min <= blue) ? rg_min : blue;
    delta  = mx - mn;
    sum    = {1'b0, mx} + {1'b0, mn};
    far    = SUM_FULL - sum;
    if (red == mx) begin
      sector = SECT_RED;
      up     = green;
      down   = blue;
    end else if (green == mx) begin
      sector = SECT_GREEN;
      up     = blue;
      down   = red;
    end else begin
      sector = SECT_BLUE;
      up     = red;
      down   = green;
    end
    // 60 * (up - down + delta), never negative
    dsum = {1'b0, up} + {1'b0, delta} - {1'b0, down};
    num  = 15'(dsum) * 15'd60;

    lane.valid   = valid;
    lane.achrom  = (delta == 8'd0);
    lane.sum     = sum;
    lane.sector  = sector;
    lane.sat_den = (sum <= SUM_HALF) ? sum[7:0] : far[7:0];
    lane.sat_rem = {1'b0, delta};
    lane.sat_q   = '0;
    lane.hue_den = delta;
    lane.hue_rem = num[14:7];
    lane.hue_lo  = num[6:0];
    lane.hue_q   = '0;
  end
endmodule

### src/rthsl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthsl_cell
// One restoring division step for saturation and, in the first cells, for hue.
// ----------------------------------------------------------------------------
module rthsl_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  rthsl_pkg::lane_t lane_in,
  output rthsl_pkg::lane_t lane_out
);
  import rthsl_pkg::*;

  lane_t      nxt;
  logic       s_ge, h_ge;
  logic [8:0] s_diff, h_sh, h_diff;
  logic [7:0] s_keep, h_keep;

  always_comb begin
    nxt    = lane_in;
    s_ge   = lane_in.sat_rem >= {1'b0, lane_in.sat_den};
    s_diff = lane_in.sat_rem - {1'b0, lane_in.sat_den};
    s_keep = s_ge ? s_diff[7:0] : lane_in.sat_rem[7:0];
    nxt.sat_rem = {s_keep, 1'b0};
    nxt.sat_q   = {lane_in.sat_q[SAT_W-2:0], s_ge};

    h_sh   = {lane_in.hue_rem, lane_in.hue_lo[6]};
    h_ge   = h_sh >= {1'b0, lane_in.hue_den};
    h_diff = h_sh - {1'b0, lane_in.hue_den};
    h_keep = h_ge ? h_diff[7:0] : h_sh[7:0];
    if (STEP < HUE_BITS) begin
      nxt.hue_rem = h_keep;
      nxt.hue_lo  = {lane_in.hue_lo[5:0], 1'b0};
      nxt.hue_q   = {lane_in.hue_q[5:0], h_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else if (en) begin
      lane_out.valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out.achrom  <= nxt.achrom;
      lane_out.sum     <= nxt.sum;
      lane_out.sector  <= nxt.sector;
      lane_out.sat_den <= nxt.sat_den;
      lane_out.sat_rem <= nxt.sat_rem;
      lane_out.sat_q   <= nxt.sat_q;
      lane_out.hue_den <= nxt.hue_den;
      lane_out.hue_rem <= nxt.hue_rem;
      lane_out.hue_lo  <= nxt.hue_lo;
      lane_out.hue_q   <= nxt.hue_q;
    end
  end
endmodule

### src/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// pixel accept to result valid: the front register loads at the accept edge, then the 16
// cells and the output register follow
// throughput: one pixel per cycle unless stalled, 16-cell divider chain fully pipelined
// a stall on the result side holds the whole chain; ready follows the output register
// reset (rst, synchronous) clears only the valid bits; no other state is kept
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Pipelined rgb to hsl conversion built from a row of divider cells.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
  input logic        clk,
  input logic        rst,
  rthsl_pix_if.sink   pixel,
  rthsl_hsl_if.source result
);
  import rthsl_pkg::*;

  lane_t      front_lane;
  lane_t      lane [SAT_BITS+1];
  logic       en;
  logic [9:0] hue_raw;
  logic [9:0] hue_base;
  logic [9:0] hue_wrap;

  assign en          = !result.valid || result.ready;
  assign pixel.ready = en;

  rthsl_front u_front (
    .red   (pixel.red),
    .green (pixel.green),
    .blue  (pixel.blue),
    .valid (pixel.valid),
    .lane  (front_lane)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lane[0].valid <= 1'b0;
    end else if (en) begin
      lane[0].valid <= front_lane.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane[0].achrom  <= front_lane.achrom;
      lane[0].sum     <= front_lane.sum;
      lane[0].sector  <= front_lane.sector;
      lane[0].sat_den <= front_lane.sat_den;
      lane[0].sat_rem <= front_lane.sat_rem;
      lane[0].sat_q   <= front_lane.sat_q;
      lane[0].hue_den <= front_lane.hue_den;
      lane[0].hue_rem <= front_lane.hue_rem;
      lane[0].hue_lo  <= front_lane.hue_lo;
      lane[0].hue_q   <= front_lane.hue_q;
    end
  end

  for (genvar k = 0; k < SAT_BITS; k++) begin : g_cell
    rthsl_cell #(.STEP(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (lane[k]),
      .lane_out (lane[k+1])
    );
  end

  always_comb begin
    unique case (lane[SAT_BITS].sector)
      SECT_RED:   hue_base = BASE_RED;
      SECT_GREEN: hue_base = BASE_GREEN;
      SECT_BLUE:  hue_base = BASE_BLUE;
      default:    hue_base = BASE_RED;
    endcase
    hue_raw  = {3'b000, lane[SAT_BITS].hue_q} + hue_base;
    hue_wrap = (hue_raw >= FULL_TURN) ? (hue_raw - FULL_TURN) : hue_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= lane[SAT_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.lightness_sum  <= lane[SAT_BITS].sum;
      result.hue_degrees    <= lane[SAT_BITS].achrom ? '0 : hue_wrap[8:0];
      result.saturation_q15 <= lane[SAT_BITS].achrom ? '0 : lane[SAT_BITS].sat_q;
    end
  end

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.hue_degrees < 9'd360))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ({1'b0, result.saturation_q15} <= Q15_ONE))
    else $error("saturation above one");

  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturation_q15 == 16'd0) |-> (result.hue_degrees == 9'd0))
    else $error("gray word with nonzero hue");

  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(lane[SAT_BITS].valid))
    else $error("divider chain moved during stall");
endmodule
